FILE: hdl/mpool_pkg.sv
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared sizes, types and tables of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mpool_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_POOL      = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int STRIDE_MAX    = 8;

  localparam int NSLOT         = MAX_POOL - 1;
  localparam int SLOT_BITS     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
  localparam int P_BITS        = $clog2(MAX_POOL + 1);
  localparam int DY_BITS       = $clog2(MAX_POOL);
  localparam int SIDX_BITS     = $clog2(STRIDE_MAX);

  localparam int POOL_CFG_BITS = 3;
  localparam int STRIDE_BITS   = 4;
  localparam int DIM_BITS      = 11;
  localparam int POS_BITS      = 4;
  localparam int OUT_IDX_BITS  = 10;

  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  // ceil(2^RECIP_SH / s): exact quotient for any 10-bit dividend and s up to 8
  localparam int RECIP_SH      = 14;
  localparam int RECIP_BITS    = 15;
  localparam logic [RECIP_BITS-1:0] RECIP_TAB [STRIDE_MAX] = '{
    15'd16384, 15'd8192, 15'd5462, 15'd4096, 15'd3277, 15'd2731, 15'd2341, 15'd2048
  };

  typedef enum logic [ADDR_BITS-3:0] {
    REG_POOL_SIZE,
    REG_STRIDE,
    REG_PLANE_WIDTH,
    REG_PLANE_HEIGHT
  } reg_idx_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              shift_en;
    logic              cap_en;
    logic [P_BITS-1:0] pool;
  } cell_ctl_t;

endpackage

FILE: hdl/mpool_line_store.sv
// ----------------------------------------------------------------------------
// mpool_line_store
// Line buffers for the previous rows, one memory per row slot, read-first.
// ----------------------------------------------------------------------------
module mpool_line_store import mpool_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc_en,
  input  logic [COL_BITS-1:0]  addr,
  input  logic [SLOT_BITS-1:0] wr_slot,
  input  sample_t              wr_data,
  output sample_t              rd_data [NSLOT],
  output logic                 busy
);

  logic                clr_busy_r;
  logic [COL_BITS-1:0] clr_addr_r;

  // zero sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (int'(clr_addr_r) == MAX_WIDTH - 1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign busy = clr_busy_r;

  for (genvar m = 0; m < NSLOT; m++) begin : g_slot
    sample_t mem [MAX_WIDTH];
    sample_t rd_r;

    always_ff @(posedge clk) begin
      if (clr_busy_r) begin
        mem[clr_addr_r] <= '0;
      end else if (acc_en && wr_slot == SLOT_BITS'(m)) begin
        mem[addr] <= wr_data;
      end
      if (acc_en) begin
        rd_r <= mem[addr];
      end
    end

    assign rd_data[m] = rd_r;
  end

endmodule

FILE: hdl/mpool_cell.sv
// ----------------------------------------------------------------------------
// mpool_cell
// One window column: holds MAX_POOL samples, passes them on to the next
// column, and reduces its column to a maximum and its row offset.
// ----------------------------------------------------------------------------
module mpool_cell import mpool_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  sample_t            col_in [MAX_POOL],
  output sample_t            col_out [MAX_POOL],
  output sample_t            best_val,
  output logic [DY_BITS-1:0] best_dy
);

  sample_t            col_r [MAX_POOL];
  sample_t            best_val_r;
  logic [DY_BITS-1:0] best_dy_r;
  sample_t            bv;
  logic [DY_BITS-1:0] bdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '{default: '0};
    end else if (ctl.shift_en) begin
      col_r <= col_in;
    end
  end

  // oldest row first so that the topmost maximum wins a tie
  always_comb begin
    logic found;
    found = 1'b0;
    bv    = '0;
    bdy   = '0;
    for (int k = MAX_POOL - 1; k >= 0; k--) begin
      if (P_BITS'(k) < ctl.pool && (!found || col_r[k] > bv)) begin
        found = 1'b1;
        bv    = col_r[k];
        bdy   = DY_BITS'(ctl.pool - P_BITS'(k) - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      best_val_r <= bv;
      best_dy_r  <= bdy;
    end
  end

  assign col_out  = col_r;
  assign best_val = best_val_r;
  assign best_dy  = best_dy_r;

endmodule

FILE: hdl/mpool_argmax.sv
// ----------------------------------------------------------------------------
// mpool_argmax
// Merges the column results into the window maximum and its row-major index.
// ----------------------------------------------------------------------------
module mpool_argmax import mpool_pkg::*; (
  input  logic [P_BITS-1:0]   pool,
  input  sample_t             col_best [MAX_POOL],
  input  logic [DY_BITS-1:0]  col_dy [MAX_POOL],
  output sample_t             max_value,
  output logic [POS_BITS-1:0] max_position
);

  localparam int POS_CALC = DY_BITS + P_BITS + 1;

  sample_t            best;
  logic [DY_BITS-1:0] bdy;
  logic [P_BITS-1:0]  bdx;
  logic [POS_CALC-1:0] pos;

  // leftmost column first; equal value with a higher row also wins
  always_comb begin
    logic found;
    found = 1'b0;
    best  = '0;
    bdy   = '0;
    bdx   = '0;
    for (int j = MAX_POOL - 1; j >= 0; j--) begin
      if (P_BITS'(j) < pool && (!found || col_best[j] > best ||
          (col_best[j] == best && col_dy[j] < bdy))) begin
        found = 1'b1;
        best  = col_best[j];
        bdy   = col_dy[j];
        bdx   = pool - P_BITS'(j) - 1'b1;
      end
    end
    pos = POS_CALC'(bdy) * POS_CALC'(pool) + POS_CALC'(bdx);
  end

  assign max_value    = best;
  assign max_position = POS_BITS'(pos);

endmodule

FILE: hdl/max_pool_2d_argmax_stream.sv
// ----------------------------------------------------------------------------
// max_pool_2d_argmax_stream
// Streaming 2-D max pooling with arg-max, valid padding.
// Samples (signed Q8.8) enter on in_* one per transaction, raster order,
// channel planes back to back. Each window whose bottom-right sample arrives
// yields one out_* transaction: maximum, row-major position in the window
// (first wins on a tie), output row/column and a last-of-plane flag.
// Geometry is set over the APB-style port; the user must write it only while
// the block is idle, which the block does not enforce. Throughput: one
// sample per cycle while in_ready is high. From the edge that takes the
// window's last sample, out_valid follows the line store read with the
// sample, window column shift, column reduction and column merge into the
// output register. Reset: registers return to pool 2, stride 2, 1024 x 1024;
// the line store is then zeroed one column per cycle over all MAX_WIDTH
// (1024) columns with in_ready low. On a receiver stall the result holds in
// the output register; the pipeline takes samples until its stages are full.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax_stream import mpool_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_max_value,
  output logic [POS_BITS-1:0]     out_max_position,
  output logic [OUT_IDX_BITS-1:0] out_row,
  output logic [OUT_IDX_BITS-1:0] out_col,
  output logic                    out_last_of_plane,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_BITS-1:0]    paddr,
  input  logic [DATA_BITS-1:0]    pwdata,
  output logic [DATA_BITS-1:0]    prdata,
  output logic                    pready
);

  localparam int ROWX_BITS = ROW_BITS + 1;
  localparam int CPROD     = COL_BITS + RECIP_BITS;
  localparam int RPROD     = ROW_BITS + RECIP_BITS;
  localparam int CQS       = COL_BITS + STRIDE_BITS;
  localparam int RQS       = ROW_BITS + STRIDE_BITS;

  function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
    return (int'(s) == NSLOT - 1) ? '0 : s + 1'b1;
  endfunction

  // configuration registers
  logic [POOL_CFG_BITS-1:0] pool_cfg_r;
  logic [STRIDE_BITS-1:0]   stride_cfg_r;
  logic [DIM_BITS-1:0]      width_cfg_r;
  logic [DIM_BITS-1:0]      height_cfg_r;
  reg_idx_t                 reg_sel;
  logic                     cfg_wr;

  assign reg_sel = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_cfg_r   <= POOL_CFG_BITS'(2);
      stride_cfg_r <= STRIDE_BITS'(2);
      width_cfg_r  <= DIM_BITS'(1024);
      height_cfg_r <= DIM_BITS'(1024);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_POOL_SIZE:    pool_cfg_r   <= pwdata[POOL_CFG_BITS-1:0];
        REG_STRIDE:       stride_cfg_r <= pwdata[STRIDE_BITS-1:0];
        REG_PLANE_WIDTH:  width_cfg_r  <= pwdata[DIM_BITS-1:0];
        REG_PLANE_HEIGHT: height_cfg_r <= pwdata[DIM_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POOL_SIZE:    prdata = DATA_BITS'(pool_cfg_r);
      REG_STRIDE:       prdata = DATA_BITS'(stride_cfg_r);
      REG_PLANE_WIDTH:  prdata = DATA_BITS'(width_cfg_r);
      REG_PLANE_HEIGHT: prdata = DATA_BITS'(height_cfg_r);
    endcase
  end

  // effective geometry
  logic [P_BITS-1:0]      pc;
  logic [STRIDE_BITS-1:0] sc;
  logic [DIM_BITS-1:0]    wc;
  logic [DIM_BITS-1:0]    hc;
  logic [RECIP_BITS-1:0]  recip;

  always_comb begin
    if (pool_cfg_r == '0) begin
      pc = P_BITS'(1);
    end else if (int'(pool_cfg_r) > MAX_POOL) begin
      pc = P_BITS'(MAX_POOL);
    end else begin
      pc = P_BITS'(pool_cfg_r);
    end
    if (stride_cfg_r == '0) begin
      sc = STRIDE_BITS'(1);
    end else if (int'(stride_cfg_r) > STRIDE_MAX) begin
      sc = STRIDE_BITS'(STRIDE_MAX);
    end else begin
      sc = stride_cfg_r;
    end
    if (width_cfg_r == '0) begin
      wc = DIM_BITS'(1);
    end else if (int'(width_cfg_r) > MAX_WIDTH) begin
      wc = DIM_BITS'(MAX_WIDTH);
    end else begin
      wc = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      hc = DIM_BITS'(1);
    end else if (int'(height_cfg_r) > MAX_HEIGHT) begin
      hc = DIM_BITS'(MAX_HEIGHT);
    end else begin
      hc = height_cfg_r;
    end
  end

  assign recip = RECIP_TAB[SIDX_BITS'(sc - 1'b1)];

  // index of the last window in each direction
  logic [COL_BITS-1:0] lim_cn;
  logic [ROW_BITS-1:0] lim_rn;
  logic [CPROD-1:0]    lim_cprod;
  logic [RPROD-1:0]    lim_rprod;
  logic [COL_BITS-1:0] lim_col;
  logic [ROW_BITS-1:0] lim_row;

  assign lim_cn = (wc >= DIM_BITS'(pc)) ? COL_BITS'(wc - DIM_BITS'(pc)) : '0;
  assign lim_rn = (hc >= DIM_BITS'(pc)) ? ROW_BITS'(hc - DIM_BITS'(pc)) : '0;

  assign lim_cprod = CPROD'(lim_cn) * CPROD'(recip);
  assign lim_rprod = RPROD'(lim_rn) * RPROD'(recip);
  assign lim_col   = lim_cprod[RECIP_SH +: COL_BITS];
  assign lim_row   = lim_rprod[RECIP_SH +: ROW_BITS];

  // pipeline handshake
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy_o, rdy3, rdy2, rdy1;
  logic emit2, go2, adv1, adv3, acc;
  logic ls_busy;

  assign rdy_o    = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdy_o;
  assign rdy2     = !v2_r || !emit2 || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !ls_busy && rdy1;
  assign acc      = in_valid && in_ready;
  assign adv1     = v1_r && rdy2;
  assign go2      = v2_r && emit2 && rdy3;
  assign adv3     = v3_r && rdy_o;

  // raster position of the incoming sample
  logic [COL_BITS-1:0]  col_cnt_r;
  logic [ROW_BITS-1:0]  row_cnt_r;
  logic [SLOT_BITS-1:0] slot_cnt_r;
  logic                 col_wrap, row_wrap, line_end, plane_end, win_ok;
  logic [ROWX_BITS-1:0] row_t;
  logic [SLOT_BITS-1:0] slot_t, slot_a;
  logic [COL_BITS-1:0]  col_a, nc_a;
  logic [ROW_BITS-1:0]  row_a, nr_a;
  logic [DIM_BITS-1:0]  c1, r1;

  always_comb begin
    col_wrap  = DIM_BITS'(col_cnt_r) >= wc;
    row_t     = col_wrap ? ROWX_BITS'(row_cnt_r) + 1'b1 : ROWX_BITS'(row_cnt_r);
    slot_t    = col_wrap ? slot_inc(slot_cnt_r) : slot_cnt_r;
    row_wrap  = DIM_BITS'(row_t) >= hc;
    row_a     = row_wrap ? '0 : row_t[ROW_BITS-1:0];
    slot_a    = row_wrap ? '0 : slot_t;
    col_a     = col_wrap ? '0 : col_cnt_r;
    c1        = DIM_BITS'(col_a) + 1'b1;
    r1        = DIM_BITS'(row_a) + 1'b1;
    win_ok    = (c1 >= DIM_BITS'(pc)) && (r1 >= DIM_BITS'(pc));
    nc_a      = COL_BITS'(c1 - DIM_BITS'(pc));
    nr_a      = ROW_BITS'(r1 - DIM_BITS'(pc));
    line_end  = c1 >= wc;
    plane_end = r1 >= hc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      slot_cnt_r <= '0;
    end else if (acc) begin
      if (line_end) begin
        col_cnt_r  <= '0;
        row_cnt_r  <= plane_end ? '0 : r1[ROW_BITS-1:0];
        slot_cnt_r <= plane_end ? '0 : slot_inc(slot_a);
      end else begin
        col_cnt_r  <= c1[COL_BITS-1:0];
        row_cnt_r  <= row_a;
        slot_cnt_r <= slot_a;
      end
    end
  end

  sample_t ls_rd [NSLOT];

  mpool_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (acc),
    .addr    (col_a),
    .wr_slot (slot_a),
    .wr_data (in_sample),
    .rd_data (ls_rd),
    .busy    (ls_busy)
  );

  // stage 1: sample and line store data
  sample_t              x1_r;
  logic [SLOT_BITS-1:0] slot1_r;
  logic                 ok1_r;
  logic [COL_BITS-1:0]  nc1_r;
  logic [ROW_BITS-1:0]  nr1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (acc) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x1_r    <= in_sample;
      slot1_r <= slot_a;
      ok1_r   <= win_ok;
      nc1_r   <= nc_a;
      nr1_r   <= nr_a;
    end
  end

  sample_t col_new [MAX_POOL];

  assign col_new[0] = x1_r;

  for (genvar k = 1; k < MAX_POOL; k++) begin : g_col
    localparam int KOFF = NSLOT - (k % NSLOT);
    logic [SLOT_BITS:0]   sum;
    logic [SLOT_BITS-1:0] sidx;
    assign sum  = (SLOT_BITS + 1)'(slot1_r) + (SLOT_BITS + 1)'(KOFF);
    assign sidx = (int'(sum) >= NSLOT) ? SLOT_BITS'(int'(sum) - NSLOT)
                                       : sum[SLOT_BITS-1:0];
    assign col_new[k] = ls_rd[sidx];
  end

  logic [CPROD-1:0] q1c_prod;
  logic [RPROD-1:0] q1r_prod;

  assign q1c_prod = CPROD'(nc1_r) * CPROD'(recip);
  assign q1r_prod = RPROD'(nr1_r) * RPROD'(recip);

  // stage 2: window column reduction, remainder check
  logic                ok2_r;
  logic [COL_BITS-1:0] nc2_r, qc2_r;
  logic [ROW_BITS-1:0] nr2_r, qr2_r;
  logic [CQS-1:0]      qs_c;
  logic [RQS-1:0]      qs_r;
  logic                last2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv1) begin
      v2_r <= 1'b1;
    end else if (v2_r && rdy2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ok2_r <= ok1_r;
      nc2_r <= nc1_r;
      nr2_r <= nr1_r;
      qc2_r <= q1c_prod[RECIP_SH +: COL_BITS];
      qr2_r <= q1r_prod[RECIP_SH +: ROW_BITS];
    end
  end

  assign qs_c  = CQS'(qc2_r) * CQS'(sc);
  assign qs_r  = RQS'(qr2_r) * RQS'(sc);
  assign emit2 = ok2_r && (nc2_r == qs_c[COL_BITS-1:0]) && (nr2_r == qs_r[ROW_BITS-1:0]);
  assign last2 = (qr2_r == lim_row) && (qc2_r == lim_col);

  cell_ctl_t          cell_ctl;
  sample_t            cell_col  [MAX_POOL][MAX_POOL];
  sample_t            cell_best [MAX_POOL];
  logic [DY_BITS-1:0] cell_dy   [MAX_POOL];

  assign cell_ctl.shift_en = adv1;
  assign cell_ctl.cap_en   = go2;
  assign cell_ctl.pool     = pc;

  for (genvar j = 0; j < MAX_POOL; j++) begin : g_cell
    if (j == 0) begin : g_head
      mpool_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .col_in   (col_new),
        .col_out  (cell_col[j]),
        .best_val (cell_best[j]),
        .best_dy  (cell_dy[j])
      );
    end else begin : g_tail
      mpool_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .col_in   (cell_col[j-1]),
        .col_out  (cell_col[j]),
        .best_val (cell_best[j]),
        .best_dy  (cell_dy[j])
      );
    end
  end

  // stage 3: merge columns
  logic [ROW_BITS-1:0] orow3_r;
  logic [COL_BITS-1:0] ocol3_r;
  logic                last3_r;
  sample_t             am_val;
  logic [POS_BITS-1:0] am_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (go2) begin
      v3_r <= 1'b1;
    end else if (adv3) begin
      v3_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      orow3_r <= qr2_r;
      ocol3_r <= qc2_r;
      last3_r <= last2;
    end
  end

  mpool_argmax u_argmax (
    .pool         (pc),
    .col_best     (cell_best),
    .col_dy       (cell_dy),
    .max_value    (am_val),
    .max_position (am_pos)
  );

  // output register
  sample_t                 max_value_r;
  logic [POS_BITS-1:0]     max_pos_r;
  logic [OUT_IDX_BITS-1:0] out_row_r, out_col_r;
  logic                    last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv3) begin
      vo_r <= 1'b1;
    end else if (out_ready) begin
      vo_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      max_value_r <= am_val;
      max_pos_r   <= am_pos;
      out_row_r   <= OUT_IDX_BITS'(orow3_r);
      out_col_r   <= OUT_IDX_BITS'(ocol3_r);
      last_r      <= last3_r;
    end
  end

  assign out_valid         = vo_r;
  assign out_max_value     = max_value_r;
  assign out_max_position  = max_pos_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_plane = last_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken while the line store is being cleared");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(x1_r)))
    else $error("stage 1 transaction lost under backpressure");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy_o) |=> (v3_r && $stable(orow3_r) && $stable(ocol3_r)))
    else $error("merge stage transaction lost under backpressure");

endmodule

FILE: verif/tb_max_pool_2d_argmax_stream.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_pool_2d_argmax_stream
// Self-checking bench for the streaming 2-D max pooling / arg-max block.
// A behavioral pooling model tracks line stores, window and raster position
// for every accepted sample and queues the windows it should produce; each
// output transaction is compared field by field with the oldest one. Directed
// corner cases come first, then the widest row and the top of a tall plane,
// random geometry with random sender gaps and receiver stalls, and a
// full-rate stretch.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_argmax_stream;
  import mpool_pkg::*;

  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 160;
  localparam int TALL_ITEMS    = 64;

  typedef struct {
    sample_t                 max_value;
    logic [POS_BITS-1:0]     max_position;
    logic [OUT_IDX_BITS-1:0] row;
    logic [OUT_IDX_BITS-1:0] col;
    logic                    last_of_plane;
  } pool_window_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  sample_t                 in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  sample_t                 out_max_value;
  logic [POS_BITS-1:0]     out_max_position;
  logic [OUT_IDX_BITS-1:0] out_row;
  logic [OUT_IDX_BITS-1:0] out_col;
  logic                    out_last_of_plane;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_BITS-1:0]    paddr = '0;
  logic [DATA_BITS-1:0]    pwdata = '0;
  logic [DATA_BITS-1:0]    prdata;
  logic                    pready;

  // pooling model state
  logic [POOL_CFG_BITS-1:0] geo_pool = 3'd2;
  logic [STRIDE_BITS-1:0]   geo_stride = 4'd2;
  logic [DIM_BITS-1:0]      geo_width = 11'd1024;
  logic [DIM_BITS-1:0]      geo_height = 11'd1024;
  sample_t                  line_mem [NSLOT][MAX_WIDTH];
  sample_t                  win [MAX_POOL][MAX_POOL];
  int unsigned              col_pos = 0;
  int unsigned              row_pos = 0;
  pool_window_t             pending_windows [$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned fail_count = 0;

  max_pool_2d_argmax_stream dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_max_value    (out_max_value),
    .out_max_position (out_max_position),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_plane(out_last_of_plane),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #6 clk = ~clk;

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
  end

  function automatic int unsigned limit_range(int unsigned v, int unsigned lo,
                                              int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // advance the model by one sample, queue the window it completes
  function automatic void pool_step(sample_t x);
    int unsigned  p, s, w, h, r, c, orow, ocol, pos;
    int           k, j, dy, dx;
    sample_t      column [MAX_POOL];
    sample_t      best;
    pool_window_t res;
    p = limit_range(geo_pool, 1, MAX_POOL);
    s = limit_range(geo_stride, 1, STRIDE_MAX);
    w = limit_range(geo_width, 1, MAX_WIDTH);
    h = limit_range(geo_height, 1, MAX_HEIGHT);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    column[0] = x;
    for (k = 1; k < MAX_POOL; k++)
      column[k] = line_mem[(r + NSLOT * MAX_HEIGHT - k) % NSLOT][c];
    line_mem[r % NSLOT][c] = x;
    for (k = 0; k < MAX_POOL; k++) begin
      for (j = MAX_POOL - 1; j > 0; j--) win[k][j] = win[k][j-1];
      win[k][0] = column[k];
    end
    if (c + 1 >= p && r + 1 >= p && (c + 1 - p) % s == 0 && (r + 1 - p) % s == 0) begin
      best = win[p-1][p-1];
      pos  = 0;
      for (dy = 0; dy < p; dy++)
        for (dx = 0; dx < p; dx++)
          if (win[p-1-dy][p-1-dx] > best) begin
            best = win[p-1-dy][p-1-dx];
            pos  = dy * p + dx;
          end
      orow = (r + 1 - p) / s;
      ocol = (c + 1 - p) / s;
      res.max_value     = best;
      res.max_position  = pos[POS_BITS-1:0];
      res.row           = orow[OUT_IDX_BITS-1:0];
      res.col           = ocol[OUT_IDX_BITS-1:0];
      res.last_of_plane = (orow == (h - p) / s) && (ocol == (w - p) / s);
      pending_windows.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return sample_t'($urandom);
    if (pick < 8) return sample_t'(int'($urandom_range(0, 4)) - 2);
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      default: return '0;
    endcase
  endfunction

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pool_window_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_windows.size() == 0) begin
        $error("unexpected transaction row %0d col %0d value %0d", out_row, out_col,
               out_max_value);
        fail_count++;
      end else begin
        want = pending_windows.pop_front();
        if (out_max_value !== want.max_value) begin
          $error("max_value expected %0d got %0d", want.max_value, out_max_value);
          fail_count++;
        end
        if (out_max_position !== want.max_position) begin
          $error("max_position expected %0d got %0d", want.max_position, out_max_position);
          fail_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, out_row);
          fail_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col expected %0d got %0d", want.col, out_col);
          fail_count++;
        end
        if (out_last_of_plane !== want.last_of_plane) begin
          $error("last_of_plane expected %0d got %0d", want.last_of_plane,
                 out_last_of_plane);
          fail_count++;
        end
      end
    end
  end

  task automatic send_sample(sample_t value);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    pool_step(value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_POOL_SIZE:    geo_pool   = value[POOL_CFG_BITS-1:0];
      REG_STRIDE:       geo_stride = value[STRIDE_BITS-1:0];
      REG_PLANE_WIDTH:  geo_width  = value[DIM_BITS-1:0];
      REG_PLANE_HEIGHT: geo_height = value[DIM_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned pool, int unsigned step, int unsigned width,
                              int unsigned height);
    drain();
    cfg_write(REG_POOL_SIZE, pool);
    cfg_write(REG_STRIDE, step);
    cfg_write(REG_PLANE_WIDTH, width);
    cfg_write(REG_PLANE_HEIGHT, height);
  endtask

  // 2x2 / stride 2 on a 4x2 plane: extreme values, tie resolved to first position
  task automatic test_directed_corners();
    sample_t seq [8] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1,
                         16'sd5, 16'sd5, 16'sh7fff, 16'sh7fff};
    idle_pct  = 25;
    stall_pct = 25;
    set_geometry(2, 2, 4, 2);
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // all-zero registers behave as pool 1, stride 1, width 1
  task automatic test_degenerate_geometry();
    set_geometry(0, 0, 0, 2);
    send_sample(16'sh4000);
    send_sample(16'shc000);
  endtask

  // pool and stride above range saturate; maximum at the last window position
  task automatic test_oversized_registers();
    set_geometry(7, 15, 4, 4);
    repeat (15) send_sample(-16'sd5);
    send_sample(16'sd7);
  endtask

  // plane smaller than the window: samples consumed, no transaction
  task automatic test_plane_below_window();
    set_geometry(2, 1, 1, 3);
    repeat (3) send_sample(random_sample());
  endtask

  task automatic test_widest_row();
    set_geometry(1, 3, 2047, 1);
    repeat (MAX_WIDTH) send_sample(random_sample());
  endtask

  // saturated height register, first rows of the plane only
  task automatic test_tallest_plane();
    set_geometry(1, 8, 1, 2047);
    repeat (TALL_ITEMS) send_sample(random_sample());
  endtask

  task automatic test_random_geometry();
    int unsigned sent, pool, step, width, height, pe, we, he, r, c, n, mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pool = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      step = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 15);
      pe   = limit_range(pool, 1, MAX_POOL);
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        width  = $urandom_range(pe, pe + 9);
        height = $urandom_range(pe, pe + 5);
      end else if (mode < 17) begin
        width  = $urandom_range(0, 16);
        height = $urandom_range(0, 12);
      end else begin
        width  = $urandom_range(0, 2047);
        height = $urandom_range(0, 2047);
      end
      idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 10 : 40);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 10 : 40);
      set_geometry(pool, step, width, height);
      we = limit_range(width, 1, MAX_WIDTH);
      he = limit_range(height, 1, MAX_HEIGHT);
      // finish the plane the position wraps into, then whole planes
      c = col_pos;
      r = row_pos;
      if (c >= we) begin
        c = 0;
        r++;
      end
      if (r >= he) r = 0;
      n = we * he - (r * we + c) + we * he * $urandom_range(0, 2);
      if ($urandom_range(0, 5) == 0 || n > 400) n = $urandom_range(1, 60);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) send_sample(random_sample());
      sent += n;
    end
  endtask

  task automatic test_back_to_back();
    set_geometry(3, 1, 10, 4);
    calm = 1'b1;
    repeat (120) send_sample(random_sample());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_degenerate_geometry();
    test_oversized_registers();
    test_plane_below_window();
    test_widest_row();
    test_tallest_plane();
    test_random_geometry();
    test_back_to_back();
    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
